/* src/itok_pkg.sv */
`default_nettype none
package itok_pkg;

	typedef enum logic [2:0] {
		KIND_WORD    = 3'd0,
		KIND_PUNCT   = 3'd1,
		KIND_INDENT  = 3'd2,
		KIND_NEWLINE = 3'd3,
		KIND_DEDENT  = 3'd4,
		KIND_ERROR   = 3'd5,
		KIND_END     = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		MODE_LINE_START,
		MODE_BETWEEN,
		MODE_WORD,
		MODE_PENDING,
		MODE_SKIP
	} mode_t;

	typedef enum logic [2:0] {
		PEND_NONE,
		PEND_HYPHEN,
		PEND_OPEN,
		PEND_CLOSE,
		PEND_LESS,
		PEND_GREATER
	} pend_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_TOKEN,
		ST_POP_READ,
		ST_POP_EMIT,
		ST_FLUSH,
		ST_END
	} state_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] code;
	} punct_t;

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_LF      = 8'h0a;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_HYPHEN  = 8'h2d;
	localparam logic [7:0] CH_UNDER   = 8'h5f;
	localparam logic [7:0] CH_OPEN    = 8'h5b;
	localparam logic [7:0] CH_CLOSE   = 8'h5d;
	localparam logic [7:0] CH_LESS    = 8'h3c;
	localparam logic [7:0] CH_GREATER = 8'h3e;

	localparam logic [3:0] PC_DOUBLE_OPEN    = 4'd12;
	localparam logic [3:0] PC_DOUBLE_CLOSE   = 4'd13;
	localparam logic [3:0] PC_DOUBLE_LESS    = 4'd14;
	localparam logic [3:0] PC_DOUBLE_GREATER = 4'd15;

	function automatic logic alpha_char(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
	endfunction

	function automatic logic digit_char(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_body(input logic [7:0] c);
		return alpha_char(c) || digit_char(c) || c == CH_UNDER || c == CH_HYPHEN;
	endfunction

	function automatic punct_t single_code(input logic [7:0] c);
		punct_t r;
		r.hit = 1'b1;
		case (c)
			8'h3d:   r.code = 4'd0;
			8'h5c:   r.code = 4'd1;
			8'h2e:   r.code = 4'd2;
			8'h28:   r.code = 4'd3;
			8'h29:   r.code = 4'd4;
			8'h2a:   r.code = 4'd5;
			8'h21:   r.code = 4'd6;
			8'h3b:   r.code = 4'd7;
			8'h7b:   r.code = 4'd8;
			8'h7d:   r.code = 4'd9;
			8'h3a:   r.code = 4'd10;
			8'h40:   r.code = 4'd11;
			default: begin
				r.hit  = 1'b0;
				r.code = 4'd0;
			end
		endcase
		return r;
	endfunction

	function automatic pend_t pending_of(input logic [7:0] c);
		case (c)
			CH_HYPHEN:  return PEND_HYPHEN;
			CH_OPEN:    return PEND_OPEN;
			CH_CLOSE:   return PEND_CLOSE;
			CH_LESS:    return PEND_LESS;
			CH_GREATER: return PEND_GREATER;
			default:    return PEND_NONE;
		endcase
	endfunction

	// A token start that gives a result at once: a single symbol or an error.
	function automatic logic start_emits(input logic [7:0] c);
		return c != CH_SPACE && !alpha_char(c) && pending_of(c) == PEND_NONE;
	endfunction

endpackage
`default_nettype wire

/* src/itok_stack_ram.sv */
`default_nettype none
module itok_stack_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 12
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire                      re,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

/* src/indentation_aware_tokenizer.sv */
`default_nettype none
// Channel | Direction | Handshake          | Payload
// input   | in        | in_valid, in_stall | text_byte
// output  | out       | out_valid, out_stall | token_kind, punct_code, line_index,
//         |           |                    | start_column, token_length, last_of_run
//
// Each byte is accepted into a register and then decoded; a byte that may start a token
// then goes through a token state.
// A dedent at a line start first reads the indent stack RAM, once per pop, then emits.
// Closing dedents at the end of the text come from a flush state and read no RAM.
// While out_stall is high a result waits in the output register and the next one holds decoding.
// Reset clears all control state; the stack RAM needs no clearing, as entry zero is never used.
module indentation_aware_tokenizer #(
	parameter int STACK_DEPTH = 16,
	parameter int COLUMN_BITS = 12,
	parameter int LINE_BITS   = 16
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  wire  [7:0]             text_byte,
	output logic                   out_valid,
	input  wire                    out_stall,
	output logic [2:0]             token_kind,
	output logic [3:0]             punct_code,
	output logic [LINE_BITS-1:0]   line_index,
	output logic [COLUMN_BITS-1:0] start_column,
	output logic [COLUMN_BITS-1:0] token_length,
	output logic                   last_of_run
);
	import itok_pkg::*;

	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int AW  = $clog2(STACK_DEPTH);
	localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
	localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
	localparam logic [SPW-1:0]         SP_FULL  = SPW'(STACK_DEPTH);
	localparam logic [SPW-1:0]         SP_ONE   = SPW'(1);
	localparam logic [SPW-1:0]         SP_TWO   = SPW'(2);

	state_t state_q, state_d;
	mode_t  mode_q, mode_d;
	pend_t  pend_q, pend_d;
	logic [SPW-1:0]         sp_q, sp_d;
	logic [COLUMN_BITS-1:0] top_q, top_d;
	logic [LINE_BITS-1:0]   line_q, line_d;
	logic [COLUMN_BITS-1:0] colcnt_q;
	logic [COLUMN_BITS-1:0] wsc_q, wsc_d;
	logic                   clean_q, clean_d;
	logic [7:0]             b_q;
	logic [COLUMN_BITS-1:0] col_q;

	logic                   em_valid, em_last;
	kind_t                  em_kind;
	logic [3:0]             em_code;
	logic [COLUMN_BITS-1:0] em_col, em_len;
	logic                   can_emit, adv, in_acc, restart;
	logic                   we_req, re;
	logic [AW-1:0]          waddr, raddr;
	logic [COLUMN_BITS-1:0] rdata, next_top;
	logic                   more_pop;
	punct_t                 sc;
	pend_t                  pb;

	itok_stack_ram #(.DEPTH(STACK_DEPTH), .WIDTH(COLUMN_BITS)) u_ram (
		.clk   (clk),
		.we    (we_req && adv),
		.waddr (waddr),
		.wdata (col_q),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign can_emit = !out_valid || !out_stall;
	assign adv      = !em_valid || can_emit;
	assign in_stall = state_q != ST_IDLE;
	assign in_acc   = in_valid && !in_stall;
	assign raddr    = AW'(sp_q - SP_TWO);
	assign re       = state_q == ST_POP_READ;
	assign sc       = single_code(b_q);
	assign pb       = pending_of(b_q);
	assign next_top = (sp_q == SP_TWO) ? '0 : rdata;
	assign more_pop = (sp_q - SP_ONE) > SP_ONE && col_q < next_top;

	always_comb begin
		state_d  = state_q;
		mode_d   = mode_q;
		pend_d   = pend_q;
		sp_d     = sp_q;
		top_d    = top_q;
		line_d   = line_q;
		wsc_d    = wsc_q;
		clean_d  = clean_q;
		restart  = 1'b0;
		em_valid = 1'b0;
		em_last  = 1'b1;
		em_kind  = KIND_ERROR;
		em_code  = '0;
		em_col   = col_q;
		em_len   = '0;
		we_req   = 1'b0;
		waddr    = sp_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_IDLE;
				if (b_q == CH_LF || b_q == CH_NUL) begin
					if (mode_q == MODE_WORD || mode_q == MODE_PENDING) begin
						em_valid = 1'b1;
						em_col   = wsc_q;
						em_last  = b_q == CH_LF;
						if (mode_q == MODE_WORD && clean_q) begin
							em_kind = KIND_WORD;
							em_len  = col_q - wsc_q;
						end
					end
					pend_d = PEND_NONE;
					if (b_q == CH_LF) begin
						if (line_q != LINE_MAX) begin
							line_d = line_q + 1'b1;
						end
						mode_d = MODE_LINE_START;
					end else begin
						state_d = (sp_q > SP_ONE) ? ST_FLUSH : ST_END;
					end
				end else if (mode_q == MODE_SKIP) begin
					state_d = ST_IDLE;
				end else if (col_q == COL_MAX) begin
					em_valid = 1'b1;
					em_col   = (mode_q == MODE_WORD || mode_q == MODE_PENDING) ? wsc_q : col_q;
					pend_d   = PEND_NONE;
					mode_d   = MODE_SKIP;
				end else begin
					case (mode_q)
						MODE_LINE_START: begin
							if (b_q != CH_SPACE) begin
								if (col_q > top_q) begin
									em_valid = 1'b1;
									we_req   = 1'b1;
									top_d    = col_q;
									if (sp_q < SP_FULL) begin
										em_kind = KIND_INDENT;
										em_last = !start_emits(b_q);
										sp_d    = sp_q + 1'b1;
										state_d = ST_TOKEN;
									end else begin
										waddr  = AW'(sp_q - SP_ONE);
										mode_d = MODE_SKIP;
									end
								end else if (col_q == top_q) begin
									em_valid = 1'b1;
									em_kind  = KIND_NEWLINE;
									em_last  = !start_emits(b_q);
									state_d  = ST_TOKEN;
								end else begin
									state_d = ST_POP_READ;
								end
							end
						end
						MODE_WORD: begin
							if (is_body(b_q)) begin
								clean_d = alpha_char(b_q) || digit_char(b_q);
							end else if (clean_q) begin
								em_valid = 1'b1;
								em_kind  = KIND_WORD;
								em_col   = wsc_q;
								em_len   = col_q - wsc_q;
								em_last  = !start_emits(b_q);
								state_d  = ST_TOKEN;
							end else begin
								em_valid = 1'b1;
								em_col   = wsc_q;
								mode_d   = MODE_SKIP;
							end
						end
						MODE_PENDING: begin
							pend_d = PEND_NONE;
							if (pend_q == PEND_HYPHEN && b_q == CH_HYPHEN) begin
								mode_d = MODE_SKIP;
							end else begin
								em_valid = 1'b1;
								em_col   = wsc_q;
								mode_d   = MODE_SKIP;
								if (pend_q == PEND_OPEN && b_q == CH_OPEN) begin
									em_kind = KIND_PUNCT;
									em_code = PC_DOUBLE_OPEN;
								end else if (pend_q == PEND_CLOSE && b_q == CH_CLOSE) begin
									em_kind = KIND_PUNCT;
									em_code = PC_DOUBLE_CLOSE;
								end else if (pend_q == PEND_LESS && b_q == CH_LESS) begin
									em_kind = KIND_PUNCT;
									em_code = PC_DOUBLE_LESS;
								end else if (pend_q == PEND_GREATER && b_q == CH_GREATER) begin
									em_kind = KIND_PUNCT;
									em_code = PC_DOUBLE_GREATER;
								end
								if (em_kind == KIND_PUNCT) begin
									em_len = COLUMN_BITS'(2);
									mode_d = MODE_BETWEEN;
								end
							end
						end
						default: begin
							state_d = ST_TOKEN;
						end
					endcase
				end
			end
			ST_TOKEN: begin
				state_d = ST_IDLE;
				if (b_q == CH_SPACE) begin
					mode_d = MODE_BETWEEN;
				end else if (alpha_char(b_q)) begin
					mode_d  = MODE_WORD;
					wsc_d   = col_q;
					clean_d = 1'b1;
				end else if (sc.hit) begin
					em_valid = 1'b1;
					em_kind  = KIND_PUNCT;
					em_code  = sc.code;
					em_len   = COLUMN_BITS'(1);
					mode_d   = MODE_BETWEEN;
				end else if (pb != PEND_NONE) begin
					pend_d = pb;
					mode_d = MODE_PENDING;
					wsc_d  = col_q;
				end else begin
					em_valid = 1'b1;
					mode_d   = MODE_SKIP;
				end
			end
			ST_POP_READ: begin
				state_d = ST_POP_EMIT;
			end
			ST_POP_EMIT: begin
				em_valid = 1'b1;
				em_kind  = KIND_DEDENT;
				em_last  = !more_pop && !start_emits(b_q);
				sp_d     = sp_q - SP_ONE;
				top_d    = next_top;
				state_d  = more_pop ? ST_POP_READ : ST_TOKEN;
			end
			ST_FLUSH: begin
				em_valid = 1'b1;
				em_kind  = KIND_DEDENT;
				em_col   = '0;
				em_last  = 1'b0;
				sp_d     = sp_q - SP_ONE;
				state_d  = (sp_q == SP_TWO) ? ST_END : ST_FLUSH;
			end
			ST_END: begin
				em_valid = 1'b1;
				em_kind  = KIND_END;
				restart  = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mode_q   <= MODE_LINE_START;
			pend_q   <= PEND_NONE;
			sp_q     <= SP_ONE;
			top_q    <= '0;
			line_q   <= '0;
			colcnt_q <= '0;
			wsc_q    <= '0;
			clean_q  <= 1'b0;
		end else if (restart && adv) begin
			state_q  <= ST_IDLE;
			mode_q   <= MODE_LINE_START;
			pend_q   <= PEND_NONE;
			sp_q     <= SP_ONE;
			top_q    <= '0;
			line_q   <= '0;
			colcnt_q <= '0;
			wsc_q    <= '0;
			clean_q  <= 1'b0;
		end else begin
			if (adv) begin
				state_q <= state_d;
				mode_q  <= mode_d;
				pend_q  <= pend_d;
				sp_q    <= sp_d;
				top_q   <= top_d;
				line_q  <= line_d;
				wsc_q   <= wsc_d;
				clean_q <= clean_d;
			end
			if (in_acc) begin
				if (text_byte != CH_LF && text_byte != CH_NUL && colcnt_q != COL_MAX) begin
					colcnt_q <= colcnt_q + 1'b1;
				end
			end else if (state_q == ST_DECODE && b_q == CH_LF && adv) begin
				colcnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			b_q   <= text_byte;
			col_q <= colcnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (em_valid && can_emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (em_valid && can_emit) begin
			token_kind   <= em_kind;
			punct_code   <= em_code;
			line_index   <= line_q;
			start_column <= em_col;
			token_length <= em_len;
			last_of_run  <= em_last;
		end
	end

endmodule
`default_nettype wire

/* src/itok_checker.sv */
`default_nettype none
module itok_checker #(
	parameter int COLUMN_BITS = 12,
	parameter int LINE_BITS   = 16
) (
	input wire                   clk,
	input wire                   arst_n,
	input wire                   out_valid,
	input wire                   out_stall,
	input wire [2:0]             token_kind,
	input wire [3:0]             punct_code,
	input wire [LINE_BITS-1:0]   line_index,
	input wire [COLUMN_BITS-1:0] start_column,
	input wire [COLUMN_BITS-1:0] token_length,
	input wire                   last_of_run
);
	import itok_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(token_kind) && $stable(line_index)
			&& $stable(start_column) && $stable(last_of_run))
		else $error("Stalled item changed.");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == KIND_END |-> last_of_run)
		else $error("End of text is not the last item of its byte.");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> token_kind <= KIND_END)
		else $error("Item kind out of range.");

	a_layout_bare: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind != KIND_WORD && token_kind != KIND_PUNCT
			|-> token_length == '0 && punct_code == '0)
		else $error("Layout item carries a length or a symbol code.");

endmodule

bind indentation_aware_tokenizer itok_checker #(
	.COLUMN_BITS(COLUMN_BITS),
	.LINE_BITS  (LINE_BITS)
) u_itok_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.token_kind   (token_kind),
	.punct_code   (punct_code),
	.line_index   (line_index),
	.start_column (start_column),
	.token_length (token_length),
	.last_of_run  (last_of_run)
);
`default_nettype wire
